// ===== hdl/tbn_pkg.sv =====
// ============================================================================
// tbn_pkg
// Shared types, codes and widths for the tournament barrier node engine.
// ============================================================================
package tbn_pkg;

    localparam int RANK_W             = 10;
    localparam int COUNT_W            = 11;
    localparam int LOG2_MAX_NODES_DEF = 10;

    // APB register window: two 32-bit registers at byte offsets 0 and 4
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 1;

    localparam logic [REG_IDX_W-1:0] REG_NODE_RANK  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_NODE_COUNT = 1'b1;

    localparam logic [RANK_W-1:0]  RANK_RESET  = '0;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1;

    typedef enum logic [1:0] {
        RK_ARRIVE  = 2'd0,
        RK_WAKE    = 2'd1,
        RK_RELEASE = 2'd2,
        RK_REJECT  = 2'd3
    } t_result_kind;

    typedef enum logic {
        OP_ENTRY   = 1'b0,
        OP_MESSAGE = 1'b1
    } t_operation;

    typedef enum logic {
        MK_ARRIVAL = 1'b0,
        MK_WAKEUP  = 1'b1
    } t_msg_kind;

    // barrier protocol phase
    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_ARRIVING = 2'd1,
        PH_AWAIT    = 2'd2
    } t_phase;

    // sequencer state
    typedef enum logic [1:0] {
        SQ_IDLE = 2'd0,
        SQ_EVAL = 2'd1,
        SQ_ADV  = 2'd2,
        SQ_WAKE = 2'd3
    } t_seq;

    typedef struct packed {
        logic [RANK_W-1:0]  rank;
        logic [COUNT_W-1:0] count;
    } t_cfg;

    typedef struct packed {
        t_operation        op;
        logic [RANK_W-1:0] src;
        t_msg_kind         kind;
    } t_item;

    typedef struct packed {
        logic              valid;
        t_result_kind      kind;
        logic [RANK_W-1:0] dest;
        logic              last;
    } t_emit;

    typedef struct packed {
        logic [RANK_W-1:0] dest;
        logic              partner_lt_count;
        logic              rank_lt_partner;
        logic              bit_lt_count;
    } t_pu_rsp;

endpackage

// ===== hdl/tbn_in_if.sv =====
// ============================================================================
// tbn_in_if
// Input channel: local barrier entry or received message, valid/ready.
// ============================================================================
interface tbn_in_if;
    import tbn_pkg::*;

    logic              valid;
    logic              ready;
    logic              operation;
    logic [RANK_W-1:0] msg_source;
    logic              msg_kind;

    modport source (output valid, operation, msg_source, msg_kind, input ready);
    modport sink   (input valid, operation, msg_source, msg_kind, output ready);

endinterface

// ===== hdl/tbn_out_if.sv =====
// ============================================================================
// tbn_out_if
// Result channel: sends, release and reject results, valid/ready.
// ============================================================================
interface tbn_out_if;
    import tbn_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        result_kind;
    logic [RANK_W-1:0] dest_rank;
    logic              last;

    modport source (output valid, result_kind, dest_rank, last, input ready);
    modport sink   (input valid, result_kind, dest_rank, last, output ready);

endinterface

// ===== hdl/tbn_cfg_regs.sv =====
// ============================================================================
// tbn_cfg_regs
// APB register file holding node_rank and node_count.
// ============================================================================
module tbn_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [tbn_pkg::APB_AW-1:0]   i_paddr,
    input  logic [tbn_pkg::APB_DW-1:0]   i_pwdata,
    output logic [tbn_pkg::APB_DW-1:0]   o_prdata,
    output logic                         o_pready,
    output tbn_pkg::t_cfg                o_cfg
);
    import tbn_pkg::*;

    t_cfg                 r_cfg;
    logic                 w_wr;
    logic [REG_IDX_W-1:0] w_idx;

    assign w_wr     = i_psel && i_penable && i_pwrite;
    assign w_idx    = i_paddr[APB_AW-1:2];
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rank  <= RANK_RESET;
            r_cfg.count <= COUNT_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_NODE_RANK: begin
                    r_cfg.rank <= i_pwdata[RANK_W-1:0];
                end
                REG_NODE_COUNT: begin
                    r_cfg.count <= i_pwdata[COUNT_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_NODE_RANK:  o_prdata = APB_DW'(r_cfg.rank);
            REG_NODE_COUNT: o_prdata = APB_DW'(r_cfg.count);
            default:        o_prdata = '0;
        endcase
    end

endmodule

// ===== hdl/tbn_partner_unit.sv =====
// ============================================================================
// tbn_partner_unit
// Shared partner calculator: rank XOR 2^idx and its compares against
// node_count and node_rank.
// ============================================================================
module tbn_partner_unit #(
    parameter int LOG2_MAX_NODES = tbn_pkg::LOG2_MAX_NODES_DEF
) (
    input  tbn_pkg::t_cfg                        i_cfg,
    input  logic [$clog2(LOG2_MAX_NODES+1)-1:0]  i_idx,
    output tbn_pkg::t_pu_rsp                     o_rsp
);
    import tbn_pkg::*;

    localparam int CW = (LOG2_MAX_NODES > COUNT_W) ? LOG2_MAX_NODES : COUNT_W;

    logic [CW-1:0] w_bit;
    logic [CW-1:0] w_rank;
    logic [CW-1:0] w_count;
    logic [CW-1:0] w_partner;

    assign w_bit     = CW'(1) << i_idx;
    assign w_rank    = CW'(i_cfg.rank);
    assign w_count   = CW'(i_cfg.count);
    assign w_partner = w_rank ^ w_bit;

    assign o_rsp.dest             = w_partner[RANK_W-1:0];
    assign o_rsp.partner_lt_count = w_partner < w_count;
    assign o_rsp.rank_lt_partner  = w_rank < w_partner;
    assign o_rsp.bit_lt_count     = w_bit < w_count;

endmodule

// ===== hdl/tbn_engine.sv =====
// ============================================================================
// tbn_engine
// Barrier sequencer: decodes one beat, then steps levels and wakeups one
// per cycle through the shared partner unit, unless a stalled output holds it.
// ============================================================================
module tbn_engine #(
    parameter int LOG2_MAX_NODES = tbn_pkg::LOG2_MAX_NODES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tbn_pkg::t_cfg   i_cfg,
    input  logic            i_accept,
    input  tbn_pkg::t_item  i_item,
    output logic            o_ready,
    input  logic            i_out_free,
    output tbn_pkg::t_emit  o_emit
);
    import tbn_pkg::*;

    localparam int LVL_W = $clog2(LOG2_MAX_NODES + 1);
    localparam int XW    = (LOG2_MAX_NODES > RANK_W) ? LOG2_MAX_NODES : RANK_W;
    localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LOG2_MAX_NODES);

    t_seq                      r_seq,   n_seq;
    t_phase                    r_phase, n_phase;
    logic [LVL_W-1:0]          r_level, n_level;
    logic [LVL_W-1:0]          r_j,     n_j;
    logic [LOG2_MAX_NODES-1:0] r_mask,  n_mask;
    t_item                     r_item;

    t_pu_rsp                   w_pu;
    logic [LVL_W-1:0]          w_pu_idx;
    logic [LOG2_MAX_NODES-1:0] w_lvl_bit;
    logic [LOG2_MAX_NODES-1:0] w_k_bit;
    logic [RANK_W-1:0]         w_diff;
    logic [XW-1:0]             w_diff_x;
    logic                      w_onehot;
    logic                      w_in_range;
    logic                      w_arr_ok;
    logic                      w_arr_match;
    logic                      w_wake_ok;
    logic                      w_adv_run;
    logic                      w_lvl_held;
    logic                      w_busy;

    // wakeups walk j = level..1 and address partner level j-1
    assign w_pu_idx = (r_seq == SQ_WAKE) ? (r_j - LVL_W'(1)) : r_level;

    tbn_partner_unit #(
        .LOG2_MAX_NODES (LOG2_MAX_NODES)
    ) u_partner (
        .i_cfg (i_cfg),
        .i_idx (w_pu_idx),
        .o_rsp (w_pu)
    );

    assign w_lvl_bit = LOG2_MAX_NODES'(1) << r_level;
    assign w_busy    = r_phase != PH_IDLE;

    // arrival source must sit exactly one bit k away, k inside the mask width and not yet held
    assign w_diff     = r_item.src ^ i_cfg.rank;
    assign w_diff_x   = XW'(w_diff);
    assign w_onehot   = (w_diff != '0) && ((w_diff & (w_diff - RANK_W'(1))) == '0);
    assign w_in_range = (w_diff_x >> LOG2_MAX_NODES) == '0;
    assign w_k_bit    = w_diff_x[LOG2_MAX_NODES-1:0];

    assign w_arr_ok = w_onehot && w_in_range
                   && (COUNT_W'(w_diff) < i_cfg.count)
                   && (COUNT_W'(r_item.src) < i_cfg.count)
                   && (i_cfg.rank < r_item.src)
                   && ((r_mask & w_k_bit) == '0)
                   && !(w_busy && (w_k_bit < w_lvl_bit));
    assign w_arr_match = (r_phase == PH_ARRIVING) && (w_k_bit == w_lvl_bit);

    assign w_wake_ok  = (r_phase == PH_AWAIT) && (r_level < LVL_TOP)
                     && (r_item.src == w_pu.dest);
    assign w_adv_run  = (r_level < LVL_TOP) && w_pu.bit_lt_count;
    assign w_lvl_held = (r_mask & w_lvl_bit) != '0;

    assign o_ready = r_seq == SQ_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq   <= SQ_IDLE;
            r_phase <= PH_IDLE;
            r_level <= '0;
            r_j     <= '0;
            r_mask  <= '0;
        end else begin
            r_seq   <= n_seq;
            r_phase <= n_phase;
            r_level <= n_level;
            r_j     <= n_j;
            r_mask  <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_item <= i_item;
        end
    end

    // next state
    always_comb begin
        n_seq = r_seq;
        case (r_seq)
            SQ_IDLE: begin
                if (i_accept) begin
                    n_seq = SQ_EVAL;
                end
            end
            SQ_EVAL: begin
                if (r_item.op == OP_ENTRY) begin
                    if (w_busy) begin
                        n_seq = i_out_free ? SQ_IDLE : SQ_EVAL;
                    end else begin
                        n_seq = SQ_ADV;
                    end
                end else if (r_item.kind == MK_ARRIVAL) begin
                    if (!w_arr_ok) begin
                        n_seq = i_out_free ? SQ_IDLE : SQ_EVAL;
                    end else begin
                        n_seq = w_arr_match ? SQ_ADV : SQ_IDLE;
                    end
                end else begin
                    if (w_wake_ok) begin
                        n_seq = SQ_WAKE;
                    end else begin
                        n_seq = i_out_free ? SQ_IDLE : SQ_EVAL;
                    end
                end
            end
            SQ_ADV: begin
                if (!w_adv_run) begin
                    n_seq = SQ_WAKE;
                end else if (!w_pu.partner_lt_count) begin
                    n_seq = SQ_ADV;
                end else if (w_pu.rank_lt_partner) begin
                    n_seq = w_lvl_held ? SQ_ADV : SQ_IDLE;
                end else begin
                    n_seq = i_out_free ? SQ_IDLE : SQ_ADV;
                end
            end
            SQ_WAKE: begin
                if ((r_j == '0) && i_out_free) begin
                    n_seq = SQ_IDLE;
                end
            end
            default: begin
                n_seq = SQ_IDLE;
            end
        endcase
    end

    // outputs and datapath updates
    always_comb begin
        n_phase = r_phase;
        n_level = r_level;
        n_j     = r_j;
        n_mask  = r_mask;
        o_emit  = '0;
        case (r_seq)
            SQ_EVAL: begin
                if (r_item.op == OP_ENTRY) begin
                    if (w_busy) begin
                        o_emit.valid = i_out_free;
                        o_emit.kind  = RK_REJECT;
                        o_emit.last  = 1'b1;
                    end else begin
                        n_phase = PH_ARRIVING;
                        n_level = '0;
                    end
                end else if (r_item.kind == MK_ARRIVAL) begin
                    if (!w_arr_ok) begin
                        o_emit.valid = i_out_free;
                        o_emit.kind  = RK_REJECT;
                        o_emit.last  = 1'b1;
                    end else begin
                        n_mask = r_mask | w_k_bit;
                    end
                end else begin
                    if (w_wake_ok) begin
                        n_j = r_level;
                    end else begin
                        o_emit.valid = i_out_free;
                        o_emit.kind  = RK_REJECT;
                        o_emit.last  = 1'b1;
                    end
                end
            end
            SQ_ADV: begin
                if (!w_adv_run) begin
                    // won every level: champion, start wakeups
                    n_j = r_level;
                end else if (!w_pu.partner_lt_count) begin
                    n_level = r_level + LVL_W'(1);
                end else if (w_pu.rank_lt_partner) begin
                    if (w_lvl_held) begin
                        n_mask  = r_mask & ~w_lvl_bit;
                        n_level = r_level + LVL_W'(1);
                    end
                end else begin
                    o_emit.valid = i_out_free;
                    o_emit.kind  = RK_ARRIVE;
                    o_emit.dest  = w_pu.dest;
                    o_emit.last  = 1'b1;
                    if (i_out_free) begin
                        n_phase = PH_AWAIT;
                    end
                end
            end
            SQ_WAKE: begin
                if (r_j != '0) begin
                    if (w_pu.partner_lt_count) begin
                        o_emit.valid = i_out_free;
                        o_emit.kind  = RK_WAKE;
                        o_emit.dest  = w_pu.dest;
                        if (i_out_free) begin
                            n_j = r_j - LVL_W'(1);
                        end
                    end else begin
                        n_j = r_j - LVL_W'(1);
                    end
                end else begin
                    o_emit.valid = i_out_free;
                    o_emit.kind  = RK_RELEASE;
                    o_emit.last  = 1'b1;
                    if (i_out_free) begin
                        n_phase = PH_IDLE;
                        n_level = '0;
                    end
                end
            end
            default: begin
                o_emit = '0;
            end
        endcase
    end

endmodule

// ===== hdl/tournament_barrier_node_core.sv =====
// ============================================================================
// tournament_barrier_node_core
// One node's tournament barrier engine with APB configuration.
// ============================================================================
//
//  channel   | dir | handshake           | payload
//  ----------+-----+---------------------+----------------------------------
//  i_in      | in  | valid / ready       | operation, msg_source, msg_kind
//  o_out     | out | valid / ready       | result_kind, dest_rank, last
//  APB       | in  | psel/penable/pready | paddr, pwdata, prdata
//
//  A beat is taken only in idle, then is decoded; an entry or a matching
//  arrival steps the levels one at a time, and the champion or a wakeup
//  message then walks the wakeup slots (skipped partners included) and
//  the release result, all through the single shared partner unit.
//  i_in is not ready until the sequencer is back in idle.
//  A stalled o_out holds the sequencer only on cycles that emit a result.
//  Reset is synchronous, active low, and clears phase, level and held mask.
//
module tournament_barrier_node_core #(
    parameter int LOG2_MAX_NODES = tbn_pkg::LOG2_MAX_NODES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tbn_in_if.sink                      i_in,
    tbn_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tbn_pkg::APB_AW-1:0]  paddr,
    input  logic [tbn_pkg::APB_DW-1:0]  pwdata,
    output logic [tbn_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import tbn_pkg::*;

    t_cfg              w_cfg;
    t_item             w_item;
    t_emit             w_emit;
    logic              w_ready;
    logic              w_accept;
    logic              w_out_free;

    logic              r_out_valid;
    t_result_kind      r_out_kind;
    logic [RANK_W-1:0] r_out_dest;
    logic              r_out_last;

    tbn_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (w_cfg)
    );

    assign i_in.ready  = w_ready;
    assign w_accept    = i_in.valid && w_ready;
    assign w_item.op   = t_operation'(i_in.operation);
    assign w_item.src  = i_in.msg_source;
    assign w_item.kind = t_msg_kind'(i_in.msg_kind);

    tbn_engine #(
        .LOG2_MAX_NODES (LOG2_MAX_NODES)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_accept   (w_accept),
        .i_item     (w_item),
        .o_ready    (w_ready),
        .i_out_free (w_out_free),
        .o_emit     (w_emit)
    );

    // output register; refilled in the cycle it drains
    assign w_out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit.valid) begin
            r_out_kind <= w_emit.kind;
            r_out_dest <= w_emit.dest;
            r_out_last <= w_emit.last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.result_kind = r_out_kind;
    assign o_out.dest_rank   = r_out_dest;
    assign o_out.last        = r_out_last;

endmodule

// ===== hdl/tbn_checker.sv =====
// ============================================================================
// tbn_checker
// Port-level checks for the tournament barrier node, bound to the top.
// ============================================================================
module tbn_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [1:0]                 i_out_kind,
    input logic [tbn_pkg::RANK_W-1:0] i_out_dest,
    input logic                       i_out_last
);
    import tbn_pkg::*;

    // one beat at a time: the sequencer leaves idle after every accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after an accepted beat");

    // release and reject close a beat and carry no destination
    a_terminal_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_kind == RK_RELEASE || i_out_kind == RK_REJECT))
        |-> (i_out_last && (i_out_dest == '0)))
        else $error("release/reject without last or with nonzero dest");

    // a wakeup is never marked last: the release that follows it closes the beat
    a_wake_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_kind == RK_WAKE)) |-> !i_out_last)
        else $error("wakeup result marked last");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready)
        |=> ($stable(i_out_kind) && $stable(i_out_dest) && $stable(i_out_last)))
        else $error("result payload changed while stalled");

endmodule

bind tournament_barrier_node_core tbn_checker u_tbn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.result_kind),
    .i_out_dest  (o_out.dest_rank),
    .i_out_last  (o_out.last)
);
